[hw/rtl/text_console_writer_unit_assert.svh]
// assertion macros shared by the console writer
`ifndef TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TCW_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define TCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TCW_ASSERT_IMPL(label, ante, cons)
`define TCW_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hw/rtl/tcw_pkg.sv]
package tcw_pkg;

    // command opcodes
    localparam logic [2:0] OP_PUT    = 3'd0;
    localparam logic [2:0] OP_SETCUR = 3'd1;
    localparam logic [2:0] OP_CLEAR  = 3'd2;
    localparam logic [2:0] OP_READ   = 3'd3;
    localparam logic [2:0] OP_WRPOS  = 3'd4;

    // character codes
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // configuration register indexes
    localparam logic [1:0] REG_TEXT_ATTR    = 2'd0;
    localparam logic [1:0] REG_CURSOR_GLYPH = 2'd1;
    localparam logic [1:0] REG_CURSOR_ATTR  = 2'd2;
    localparam logic [1:0] REG_DRAW_CURSOR  = 2'd3;

    // datapath commands
    typedef enum logic [4:0] {
        DP_NOP,
        DP_LATCH,
        DP_PREP,
        DP_TABMOD,
        DP_ADVANCE,
        DP_SCROLL_START,
        DP_COPY,
        DP_INIT_START,
        DP_CLEAR_START,
        DP_BLANK_START,
        DP_FILL,
        DP_SCROLL_END,
        DP_SET_NEW_POS,
        DP_SET_NEW_ZERO,
        DP_ERASE_RD,
        DP_ERASE,
        DP_DRAW,
        DP_COMMIT,
        DP_READ_RD,
        DP_READ_CAP,
        DP_WRPOS,
        DP_DIV,
        DP_SPLIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       place;
        logic       pos_ok;
        logic       sweep_last;
        logic       wrap;
    } dp_status_t;

endpackage

[hw/rtl/tcw_ctrl.sv]
module tcw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    output logic                done,
    input  tcw_pkg::dp_status_t status,
    output tcw_pkg::dp_cmd_t    cmd
);
    import tcw_pkg::*;

    typedef enum logic [4:0] {
        S_INIT, S_INITF, S_IDLE, S_PREP, S_TMOD, S_ADV, S_CHK,
        S_SCRS, S_COPY, S_DRAIN, S_BLKS, S_BLK, S_SCRE,
        S_SETPOS, S_CLRS, S_CLR, S_CLRE,
        S_ERRD, S_ERASE, S_DRAW, S_COMMIT,
        S_RDA, S_RDC, S_WRP, S_DIV, S_SPLIT
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    // next state and datapath command
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        cmd.op     = DP_NOP;
        case (state_reg)
            S_INIT:
            begin
                cmd.op     = DP_INIT_START;
                state_next = S_INITF;
            end
            S_INITF:
            begin
                cmd.op = DP_FILL;
                if (status.sweep_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = DP_LATCH;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.op     = DP_PREP;
                state_next = S_TMOD;
            end
            S_TMOD:
            begin
                cmd.op = DP_TABMOD;
                case (status.op)
                    OP_PUT:    state_next = S_ADV;
                    OP_SETCUR: state_next = status.pos_ok ? S_SETPOS : S_DIV;
                    OP_CLEAR:  state_next = S_CLRS;
                    OP_READ:   state_next = S_RDA;
                    OP_WRPOS:  state_next = S_WRP;
                    default:   state_next = S_DIV;
                endcase
            end
            S_ADV:
            begin
                cmd.op     = DP_ADVANCE;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (status.wrap)
                    state_next = S_SCRS;
                else if (status.place)
                    state_next = S_ERRD;
                else
                    state_next = S_COMMIT;
            end
            S_SCRS:
            begin
                cmd.op     = DP_SCROLL_START;
                state_next = S_COPY;
            end
            S_COPY:
            begin
                cmd.op = DP_COPY;
                if (status.sweep_last)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                state_next = S_BLKS;
            end
            S_BLKS:
            begin
                cmd.op     = DP_BLANK_START;
                state_next = S_BLK;
            end
            S_BLK:
            begin
                cmd.op = DP_FILL;
                if (status.sweep_last)
                    state_next = S_SCRE;
            end
            S_SCRE:
            begin
                cmd.op     = DP_SCROLL_END;
                state_next = status.place ? S_ERRD : S_COMMIT;
            end
            S_SETPOS:
            begin
                cmd.op     = DP_SET_NEW_POS;
                state_next = S_ERRD;
            end
            S_CLRS:
            begin
                cmd.op     = DP_CLEAR_START;
                state_next = S_CLR;
            end
            S_CLR:
            begin
                cmd.op = DP_FILL;
                if (status.sweep_last)
                    state_next = S_CLRE;
            end
            S_CLRE:
            begin
                cmd.op     = DP_SET_NEW_ZERO;
                state_next = S_ERRD;
            end
            S_ERRD:
            begin
                cmd.op     = DP_ERASE_RD;
                state_next = S_ERASE;
            end
            S_ERASE:
            begin
                cmd.op     = DP_ERASE;
                state_next = S_DRAW;
            end
            S_DRAW:
            begin
                cmd.op     = DP_DRAW;
                state_next = S_DIV;
            end
            S_COMMIT:
            begin
                cmd.op     = DP_COMMIT;
                state_next = S_DIV;
            end
            S_RDA:
            begin
                cmd.op     = DP_READ_RD;
                state_next = S_RDC;
            end
            S_RDC:
            begin
                cmd.op     = DP_READ_CAP;
                state_next = S_DIV;
            end
            S_WRP:
            begin
                cmd.op     = DP_WRPOS;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op     = DP_DIV;
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                cmd.op     = DP_SPLIT;
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

[hw/rtl/tcw_dp.sv]
module tcw_dp #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tcw_pkg::dp_cmd_t    cmd,
    output tcw_pkg::dp_status_t status,
    input  logic [2:0]          opcode,
    input  logic [7:0]          char_code,
    input  logic [6:0]          col,
    input  logic [4:0]          row,
    input  logic                place_cursor,
    input  logic                cfg_valid,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    output logic [6:0]          cursor_col,
    output logic [4:0]          cursor_row,
    output logic [7:0]          cell_char,
    output logic [7:0]          cell_attr,
    output logic                scrolled
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int NW    = $clog2(CELLS + COLUMNS);
    localparam int PW    = $clog2(32 * COLUMNS + 128);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int TW    = $clog2(TAB_STOP + 1);
    localparam int KS    = AW + 1;
    localparam int MW    = AW + KS;
    localparam int RC    = (2 ** KS) / COLUMNS;
    localparam int RT    = (2 ** KS) / TAB_STOP;
    localparam int LAST_ROW = (ROWS - 1) * COLUMNS;

    // latched command
    logic [2:0]    op_reg;
    logic [7:0]    ch_reg;
    logic [6:0]    col_in_reg;
    logic [4:0]    row_in_reg;
    logic          place_reg;

    // cursor and tracking state
    logic [PW-1:0] pos_reg;
    logic [AW-1:0] qt_reg;
    logic [TW-1:0] rt_reg;
    logic [AW-1:0] cur_off_reg;
    logic [NW-1:0] new_off_reg;
    logic [AW-1:0] drawn_off_reg;
    logic          drawn_v_reg;
    logic [AW-1:0] qc_reg;
    logic [CW-1:0] out_col_reg;
    logic [RW-1:0] out_row_reg;
    logic [7:0]    cell_char_reg;
    logic [7:0]    cell_attr_reg;
    logic          scrolled_reg;

    // sweep and copy pipeline
    logic [AW-1:0] sweep_reg;
    logic [15:0]   fill_val_reg;
    logic          cp_v_reg;
    logic [AW-1:0] cp_dst_reg;
    logic [15:0]   rdata_reg;

    // configuration
    logic [7:0]    text_attr_reg;
    logic [7:0]    glyph_reg;
    logic [7:0]    cur_attr_reg;
    logic          draw_en_reg;

    logic [15:0]   mem [CELLS];

    logic          we;
    logic [AW-1:0] wa;
    logic [15:0]   wd;
    logic [AW-1:0] ra;

    logic          pos_ok;
    logic          is_ctrl_char;
    logic [15:0]   text_cell;
    logic [15:0]   space_cell;
    logic [15:0]   cursor_cell;
    logic          erase_hit;
    logic [MW-1:0] prod_t;
    logic [MW-1:0] prod_c;
    logic [AW:0]   tdiff;
    logic [AW:0]   cdiff;
    logic          cfix;
    logic [TW-1:0] rt_next;
    logic [NW-1:0] adv_next;

    // cell values and flags
    assign pos_ok       = (32'(pos_reg) < 32'(CELLS));
    assign is_ctrl_char = (ch_reg == CH_NEWLINE) || (ch_reg == CH_TAB);
    assign text_cell    = {text_attr_reg, ch_reg};
    assign space_cell   = {text_attr_reg, CH_SPACE};
    assign cursor_cell  = {cur_attr_reg, glyph_reg};
    assign erase_hit    = drawn_v_reg && (rdata_reg == cursor_cell);

    // remainder of the cursor offset by the tab stop
    assign prod_t  = MW'(cur_off_reg) * MW'(RT);
    assign tdiff   = (AW+1)'(cur_off_reg) - (AW+1)'(qt_reg) * (AW+1)'(TAB_STOP);
    assign rt_next = (tdiff >= (AW+1)'(TAB_STOP)) ? TW'(tdiff - (AW+1)'(TAB_STOP))
                                                   : TW'(tdiff);

    // column and row of the cursor offset
    assign prod_c = MW'(cur_off_reg) * MW'(RC);
    assign cdiff  = (AW+1)'(cur_off_reg) - (AW+1)'(qc_reg) * (AW+1)'(COLUMNS);
    assign cfix   = (cdiff >= (AW+1)'(COLUMNS));

    // offset after put char
    always_comb
    begin
        if (ch_reg == CH_NEWLINE)
            adv_next = NW'(cur_off_reg) + NW'(COLUMNS) - NW'(out_col_reg);
        else if (ch_reg == CH_TAB)
            adv_next = NW'(cur_off_reg) + NW'(TAB_STOP) - NW'(rt_reg);
        else
            adv_next = NW'(cur_off_reg) + NW'(1);
    end

    // memory port selection
    always_comb
    begin
        we = cp_v_reg;
        wa = cp_dst_reg;
        wd = rdata_reg;
        ra = AW'(pos_reg);
        case (cmd.op)
            DP_FILL:
            begin
                we = 1'b1;
                wa = sweep_reg;
                wd = fill_val_reg;
            end
            DP_ADVANCE:
            begin
                we = !is_ctrl_char;
                wa = cur_off_reg;
                wd = text_cell;
            end
            DP_ERASE:
            begin
                we = erase_hit;
                wa = drawn_off_reg;
                wd = space_cell;
            end
            DP_DRAW:
            begin
                we = draw_en_reg;
                wa = AW'(new_off_reg);
                wd = cursor_cell;
            end
            DP_WRPOS:
            begin
                we = pos_ok;
                wa = AW'(pos_reg);
                wd = text_cell;
            end
            DP_COPY:     ra = sweep_reg;
            DP_ERASE_RD: ra = drawn_off_reg;
            default:
            begin
            end
        endcase
    end

    // cell store
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rdata_reg <= mem[ra];
    end

    // datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_off_reg   <= '0;
            drawn_off_reg <= '0;
            drawn_v_reg   <= 1'b0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            cell_char_reg <= '0;
            cell_attr_reg <= '0;
            scrolled_reg  <= 1'b0;
            cp_v_reg      <= 1'b0;
            text_attr_reg <= 8'd7;
            glyph_reg     <= 8'd219;
            cur_attr_reg  <= 8'd15;
            draw_en_reg   <= 1'b0;
        end
        else
        begin
            cp_v_reg <= (cmd.op == DP_COPY);
            case (cmd.op)
                DP_LATCH:
                begin
                    scrolled_reg  <= 1'b0;
                    cell_char_reg <= '0;
                    cell_attr_reg <= '0;
                end
                DP_SCROLL_START:
                begin
                    if (drawn_off_reg >= AW'(COLUMNS))
                        drawn_off_reg <= drawn_off_reg - AW'(COLUMNS);
                    else
                        drawn_v_reg <= 1'b0;
                end
                DP_SCROLL_END:   scrolled_reg <= 1'b1;
                DP_SET_NEW_ZERO: drawn_v_reg <= 1'b0;
                DP_ERASE:
                begin
                    if (erase_hit)
                        drawn_v_reg <= 1'b0;
                end
                DP_DRAW:
                begin
                    if (draw_en_reg)
                    begin
                        drawn_off_reg <= AW'(new_off_reg);
                        drawn_v_reg   <= 1'b1;
                    end
                    cur_off_reg <= AW'(new_off_reg);
                end
                DP_COMMIT: cur_off_reg <= AW'(new_off_reg);
                DP_READ_CAP:
                begin
                    if (pos_ok)
                    begin
                        cell_char_reg <= rdata_reg[7:0];
                        cell_attr_reg <= rdata_reg[15:8];
                    end
                end
                DP_SPLIT:
                begin
                    out_col_reg <= cfix ? CW'(cdiff - (AW+1)'(COLUMNS)) : CW'(cdiff);
                    out_row_reg <= RW'(qc_reg + AW'(cfix));
                end
                default:
                begin
                end
            endcase
            // configuration transfer
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_TEXT_ATTR:    text_attr_reg <= cfg_data;
                    REG_CURSOR_GLYPH: glyph_reg <= cfg_data;
                    REG_CURSOR_ATTR:  cur_attr_reg <= cfg_data;
                    REG_DRAW_CURSOR:  draw_en_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cp_dst_reg <= sweep_reg - AW'(COLUMNS);
        case (cmd.op)
            DP_LATCH:
            begin
                op_reg     <= opcode;
                ch_reg     <= char_code;
                col_in_reg <= col;
                row_in_reg <= row;
                place_reg  <= place_cursor;
            end
            DP_PREP:
            begin
                pos_reg <= PW'(row_in_reg) * PW'(COLUMNS) + PW'(col_in_reg);
                qt_reg  <= prod_t[MW-1:KS];
            end
            DP_TABMOD:  rt_reg <= rt_next;
            DP_ADVANCE: new_off_reg <= adv_next;
            DP_SCROLL_START: sweep_reg <= AW'(COLUMNS);
            DP_COPY, DP_FILL: sweep_reg <= sweep_reg + AW'(1);
            DP_INIT_START:
            begin
                sweep_reg    <= '0;
                fill_val_reg <= '0;
            end
            DP_CLEAR_START:
            begin
                sweep_reg    <= '0;
                fill_val_reg <= space_cell;
            end
            DP_BLANK_START:
            begin
                sweep_reg    <= AW'(LAST_ROW);
                fill_val_reg <= space_cell;
            end
            DP_SCROLL_END:   new_off_reg <= NW'(LAST_ROW);
            DP_SET_NEW_POS:  new_off_reg <= NW'(pos_reg);
            DP_SET_NEW_ZERO: new_off_reg <= '0;
            DP_DIV:          qc_reg <= prod_c[MW-1:KS];
            default:
            begin
            end
        endcase
    end

    // status to the controller
    assign status.op         = op_reg;
    assign status.place      = place_reg;
    assign status.pos_ok     = pos_ok;
    assign status.sweep_last = (sweep_reg == AW'(CELLS - 1));
    assign status.wrap       = (new_off_reg >= NW'(CELLS));

    assign cursor_col = 7'(out_col_reg);
    assign cursor_row = 5'(out_row_reg);
    assign cell_char  = cell_char_reg;
    assign cell_attr  = cell_attr_reg;
    assign scrolled   = scrolled_reg;

endmodule

[hw/rtl/text_console_writer_unit.sv]
// Text console writer. A command is taken when start is high and busy is low;
// its result appears for exactly one cycle with done high and cannot be held
// off, so the receiver must take it then. After reset the block clears the
// COLUMNS*ROWS cell store with busy high. Commands run one at a time. Placing
// the cursor on a put char adds the read, erase and draw of the tracked cell.
// A scroll and a clear both walk the cell memory one cell per cycle through
// its one read and one write port. The next command may be taken in the done
// cycle. Configuration transfers are always taken (cfg_ready is tied high).
module text_console_writer_unit #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] opcode,
    input  logic [7:0] char_code,
    input  logic [6:0] col,
    input  logic [4:0] row,
    input  logic       place_cursor,
    output logic       done,
    output logic [6:0] cursor_col,
    output logic [4:0] cursor_row,
    output logic [7:0] cell_char,
    output logic [7:0] cell_attr,
    output logic       scrolled,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import tcw_pkg::*;

    `include "text_console_writer_unit_assert.svh"

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    // sequencer
    tcw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .done   (done),
        .status (status),
        .cmd    (cmd)
    );

    // cell store and cursor datapath
    tcw_dp #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .opcode       (opcode),
        .char_code    (char_code),
        .col          (col),
        .row          (row),
        .place_cursor (place_cursor),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cursor_col   (cursor_col),
        .cursor_row   (cursor_row),
        .cell_char    (cell_char),
        .cell_attr    (cell_attr),
        .scrolled     (scrolled)
    );

    // checks
    `TCW_ASSERT_IMPL(a_done_when_idle, done, !busy)
    `TCW_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
    `TCW_ASSERT_NEXT(a_done_single, done, !done)
    `TCW_ASSERT_IMPL(a_scroll_col_zero, done && scrolled, cursor_col == 7'd0)

endmodule
